// ===== sv/swa_pkg.sv =====
// ----------------------------------------------------------------------------
// swa_pkg
// shared constants, types and state codes of the sliding window average block
// ----------------------------------------------------------------------------
package swa_pkg;

    // default sizes, handed to the top-level parameters
    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // window length register and configuration port
    localparam int LEN_BITS   = 7;
    localparam int ADDR_BITS  = 3;
    localparam int APB_BITS   = 32;
    localparam logic [LEN_BITS-1:0] LEN_RESET = 7'd4;

    // register index taken from paddr[2]
    localparam logic REG_WINDOW_LENGTH = 1'b0;

    // control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_LAUNCH,
        ST_DIVIDE
    } swa_state_t;

    // commands from the sequencer to the divider
    typedef struct packed {
        logic start;
        logic take;
    } div_ctrl_t;

endpackage

// ===== sv/swa_history.sv =====
// ----------------------------------------------------------------------------
// swa_history
// sample ring memory, one write and one registered read port
// ----------------------------------------------------------------------------
module swa_history #(
    parameter int DEPTH = swa_pkg::WINDOW_MAX_DEF,
    parameter int WIDTH = swa_pkg::SAMPLE_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/swa_divider.sv =====
// ----------------------------------------------------------------------------
// swa_divider
// restoring signed divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module swa_divider #(
    parameter int DIVIDEND_BITS = 22,
    parameter int DIVISOR_BITS  = 7,
    parameter int QUOT_BITS     = swa_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  swa_pkg::div_ctrl_t              ctrl,
    input  logic signed [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]         divisor,
    output logic                            done,
    output logic signed [QUOT_BITS-1:0]     quotient
);

    localparam int CNT_BITS = (DIVIDEND_BITS > 1) ? $clog2(DIVIDEND_BITS) : 1;
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DIVIDEND_BITS - 1);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CNT_BITS-1:0]      count_reg, count_next;
    logic                     neg_reg, neg_next;
    logic [DIVIDEND_BITS-1:0] shift_reg, shift_next;
    logic [DIVISOR_BITS-1:0]  rem_reg, rem_next;

    logic [DIVISOR_BITS:0]    trial;
    logic [DIVISOR_BITS+1:0]  diff;
    logic                     fits;
    logic [QUOT_BITS-1:0]     q_mag;

    // one restoring step: shift in the next dividend bit and try the subtract
    assign trial = {rem_reg, shift_reg[DIVIDEND_BITS-1]};
    assign diff  = {1'b0, trial} - {2'b00, divisor};
    assign fits  = ~diff[DIVISOR_BITS+1];

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = done_reg;
        count_next = count_reg;
        neg_next   = neg_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        if (ctrl.start)
        begin
            busy_next  = 1'b1;
            done_next  = 1'b0;
            count_next = '0;
            neg_next   = dividend[DIVIDEND_BITS-1];
            shift_next = dividend[DIVIDEND_BITS-1] ? (~dividend + 1'b1) : dividend;
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            // quotient bits enter at the bottom as dividend bits leave the top
            shift_next = {shift_reg[DIVIDEND_BITS-2:0], fits};
            rem_next   = fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
            count_next = count_reg + 1'b1;
            if (count_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (ctrl.take)
        begin
            done_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    // restore the sign of the quotient
    assign q_mag    = shift_reg[QUOT_BITS-1:0];
    assign quotient = neg_reg ? (~q_mag + 1'b1) : q_mag;
    assign done     = done_reg;

endmodule

// ===== sv/sliding_window_average_top.sv =====
// ----------------------------------------------------------------------------
// sliding_window_average_top
// streaming boxcar moving average with a bit-serial divider
// ----------------------------------------------------------------------------
// Samples arrive on the s_ stream: s_tdata carries the signed sample and
// s_tuser the restart flag, which starts a new series and drops the history.
// Once window_length samples of a series are in, each sample gives one
// average on the m_ stream (running sum / window_length, truncated toward
// zero); earlier samples give none. window_length is written over the APB
// port at address 0; the user must write it only while the stream is idle,
// which the block does not enforce. A write in idle also starts a new series
// and holds s_tready low in its access cycle. Values 0 and above WINDOW_MAX
// act as 1 and WINDOW_MAX. A sample with a result waits on the divider, which
// retires one quotient bit per cycle; a sample without result returns to idle
// straight after the ring update, without a division. One sample
// is in work at a time; the next is accepted the cycle after the result is
// loaded into the output register, so a stalled m_tready holds one result
// while one more sample is taken. Reset sets window_length to 4 and empties
// the series; the history memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module sliding_window_average_top #(
    parameter int WINDOW_MAX  = swa_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,   // sample
    input  logic                                  s_tuser,   // restart
    // output stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_tdata,   // average
    // configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [swa_pkg::ADDR_BITS-1:0]         paddr,
    input  logic [swa_pkg::APB_BITS-1:0]          pwdata,
    output logic [swa_pkg::APB_BITS-1:0]          prdata,
    output logic                                  pready
);

    localparam int DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int PTR_BITS  = $clog2(WINDOW_MAX);
    localparam int EFF_BITS  = $clog2(WINDOW_MAX + 1);
    localparam int SUM_BITS  = SAMPLE_BITS + PTR_BITS;
    localparam int CMP_BITS  = (EFF_BITS > swa_pkg::LEN_BITS) ? EFF_BITS : swa_pkg::LEN_BITS;

    swa_pkg::swa_state_t state_reg, state_next;

    logic [swa_pkg::LEN_BITS-1:0] wl_reg, wl_next;
    logic [EFF_BITS-1:0]          len;
    logic [CMP_BITS-1:0]          wl_ext;

    logic [PTR_BITS-1:0]          wp_reg, wp_next;
    logic [EFF_BITS-1:0]          fill_reg, fill_next;
    logic signed [SUM_BITS-1:0]   sum_reg, sum_next;
    logic [SAMPLE_BITS-1:0]       sample_reg, sample_next;

    logic                         out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0]       out_data_reg, out_data_next;

    logic                         cfg_write;
    logic                         in_accept;
    logic [PTR_BITS-1:0]          wp_start;
    logic [EFF_BITS-1:0]          wp_inc;
    logic                         full_now;

    logic                         mem_wr_en;
    logic                         mem_rd_en;
    logic [SAMPLE_BITS-1:0]       old_sample;

    swa_pkg::div_ctrl_t           div_ctrl;
    logic                         div_done;
    logic signed [SAMPLE_BITS-1:0] div_quot;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite &&
                       (paddr[2] == swa_pkg::REG_WINDOW_LENGTH);
    assign prdata    = (paddr[2] == swa_pkg::REG_WINDOW_LENGTH) ?
                       swa_pkg::APB_BITS'(wl_reg) : '0;
    assign wl_next   = cfg_write ? pwdata[swa_pkg::LEN_BITS-1:0] : wl_reg;

    // effective window length, zero as one and large values saturated
    assign wl_ext = CMP_BITS'(wl_reg);
    always_comb
    begin
        priority if (wl_reg == '0)
            len = EFF_BITS'(1);
        else if (wl_ext > CMP_BITS'(WINDOW_MAX))
            len = EFF_BITS'(WINDOW_MAX);
        else
            len = EFF_BITS'(wl_ext);
    end

    // write pointer at the start of a transaction, wrapped to the window
    assign in_accept = s_tvalid && s_tready;
    assign wp_start  = (s_tuser || (EFF_BITS'(wp_reg) >= len)) ? '0 : wp_reg;
    assign wp_inc    = EFF_BITS'(wp_reg) + 1'b1;
    assign full_now  = (fill_reg >= len);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        sample_next    = sample_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        s_tready       = 1'b0;
        mem_rd_en      = 1'b0;
        mem_wr_en      = 1'b0;
        div_ctrl       = '0;

        unique case (state_reg)
            swa_pkg::ST_IDLE:
            begin
                // no transaction is taken while a register write clears the series
                s_tready = !cfg_write;
                if (cfg_write)
                begin
                    sum_next  = '0;
                    fill_next = '0;
                    wp_next   = '0;
                end
                else if (in_accept)
                begin
                    // latch the sample and fetch the entry it replaces
                    mem_rd_en   = 1'b1;
                    sample_next = s_tdata[SAMPLE_BITS-1:0];
                    wp_next     = wp_start;
                    if (s_tuser)
                    begin
                        sum_next  = '0;
                        fill_next = '0;
                    end
                    state_next = swa_pkg::ST_UPDATE;
                end
            end
            swa_pkg::ST_UPDATE:
            begin
                // running sum and fill count, sample goes into the ring
                mem_wr_en = 1'b1;
                if (full_now)
                begin
                    fill_next = len;
                    sum_next  = sum_reg + SUM_BITS'($signed(sample_reg))
                                - SUM_BITS'($signed(old_sample));
                end
                else
                begin
                    fill_next = fill_reg + 1'b1;
                    sum_next  = sum_reg + SUM_BITS'($signed(sample_reg));
                end
                wp_next = (wp_inc >= len) ? '0 : wp_inc[PTR_BITS-1:0];
                if (full_now || ((fill_reg + 1'b1) >= len))
                    state_next = swa_pkg::ST_LAUNCH;
                else
                    state_next = swa_pkg::ST_IDLE;
            end
            swa_pkg::ST_LAUNCH:
            begin
                div_ctrl.start = 1'b1;
                state_next     = swa_pkg::ST_DIVIDE;
            end
            swa_pkg::ST_DIVIDE:
            begin
                // hand the quotient to the output register once it is free
                if (div_done && (!out_valid_reg || m_tready))
                begin
                    div_ctrl.take  = 1'b1;
                    out_valid_next = 1'b1;
                    out_data_next  = div_quot;
                    state_next     = swa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swa_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swa_pkg::ST_IDLE;
            wl_reg        <= swa_pkg::LEN_RESET;
            wp_reg        <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wl_reg        <= wl_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        out_data_reg <= out_data_next;
    end

    // sample ring
    swa_history #(
        .DEPTH (WINDOW_MAX),
        .WIDTH (SAMPLE_BITS)
    ) u_history (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (wp_reg),
        .wr_data (sample_reg),
        .rd_en   (mem_rd_en),
        .rd_addr (wp_start),
        .rd_data (old_sample)
    );

    // bit-serial divider
    swa_divider #(
        .DIVIDEND_BITS (SUM_BITS),
        .DIVISOR_BITS  (EFF_BITS),
        .QUOT_BITS     (SAMPLE_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (sum_reg),
        .divisor  (len),
        .done     (div_done),
        .quotient (div_quot)
    );

    // output stream
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DATA_BITS'(out_data_reg);

endmodule
